### design/complex_arithmetic_unit_assert.svh
// assertion helpers for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the unit clock outside reset
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cau_pkg.sv
package cau_pkg;

  localparam int DataWidth = 16;
  localparam int ProdWidth = 2 * DataWidth;

  typedef enum logic [2:0] {
    OpAdd   = 3'd0,
    OpSub   = 3'd1,
    OpMul   = 3'd2,
    OpDiv   = 3'd3,
    OpRecip = 3'd4,
    OpMag   = 3'd5,
    OpConj  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDivZero = 2'd1,
    StSat     = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [DataWidth-1:0] a_re;
    logic signed [DataWidth-1:0] a_im;
    logic signed [DataWidth-1:0] b_re;
    logic signed [DataWidth-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_re;
    logic signed [DataWidth-1:0] res_im;
    logic [1:0]                  status;
  } rsp_t;

  // products out of the multiplier stage
  typedef struct packed {
    logic [2:0]                  op;
    logic signed [DataWidth-1:0] a_re;
    logic signed [DataWidth-1:0] a_im;
    logic signed [DataWidth-1:0] b_re;
    logic signed [DataWidth-1:0] b_im;
    logic signed [ProdWidth-1:0] p_rr;
    logic signed [ProdWidth-1:0] p_ii;
    logic signed [ProdWidth-1:0] p_ir;
    logic signed [ProdWidth-1:0] p_ri;
    logic [ProdWidth-1:0]        sq_x;
    logic [ProdWidth-1:0]        sq_y;
  } prod_t;

  // per-request flags and early results that ride along the divider
  typedef struct packed {
    logic [2:0]           op;
    logic [DataWidth-1:0] res_re;
    logic [DataWidth-1:0] res_im;
    logic                 sat;
    logic                 zero;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
  } side_t;

  // divider and square root working state
  typedef struct packed {
    logic [ProdWidth-1:0] d;
    logic [ProdWidth-1:0] rem_re;
    logic [ProdWidth-1:0] rem_im;
    logic [DataWidth-1:0] lo_re;
    logic [DataWidth-1:0] lo_im;
    logic [DataWidth-1:0] q_re;
    logic [DataWidth-1:0] q_im;
    logic [DataWidth+1:0] sq_rem;
    logic [DataWidth-1:0] sq_root;
    logic [ProdWidth-1:0] sq_v;
  } iter_t;

  // sign and magnitude to saturated value, sat flag on top
  function automatic logic [DataWidth:0] pack_mag(input logic neg,
                                                  input logic [ProdWidth:0] mag);
    logic [ProdWidth:0]   lim;
    logic [DataWidth-1:0] v;
    logic                 sat;
    lim = (ProdWidth+1)'(1) << (DataWidth - 1);
    if (!neg) lim = lim - (ProdWidth+1)'(1);
    sat = mag > lim;
    v = sat ? lim[DataWidth-1:0] : mag[DataWidth-1:0];
    if (neg) v = -v;
    return {sat, v};
  endfunction

  function automatic logic [ProdWidth:0] abs_s(input logic signed [ProdWidth:0] v);
    return v[ProdWidth] ? (ProdWidth+1)'(-v) : (ProdWidth+1)'(v);
  endfunction

  function automatic logic [DataWidth:0] clamp_s(input logic signed [ProdWidth:0] v);
    return pack_mag(v[ProdWidth], abs_s(v));
  endfunction

endpackage

### design/complex_arithmetic_unit.sv
// channel   direction  handshake                 payload
// request   in         in_valid_i / in_ready_o   in_req_i   (req_t)
// response  out        out_valid_o / out_ready_i out_rsp_o  (rsp_t)
//
// one request per cycle unless every stage is full behind a held response;
// the stages are the multiplier stage, two prep stages, one radix-2 divider /
// root stage per quotient bit and the output register
// rst_ni clears only the valid bits of the pipeline
// a stage advances when it is empty or the stage after it advances, so bubbles
// close up and requests keep entering while a response waits at the output
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FracBits = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int NumSteps  = DataWidth;
  localparam int NumStages = NumSteps + 4;

  logic [NumStages-1:0] v_d, v_q, en;
  prod_t                prod;
  side_t                side_s [NumSteps+1];
  iter_t                iter_s [NumSteps+1];

  for (genvar k = 0; k < NumStages; k++) begin : g_en
    assign en[k] = out_ready_i || !(&v_q[NumStages-1:k]);
  end

  always_comb begin
    v_d = {v_q[NumStages-2:0], in_valid_i};
    for (int k = 0; k < NumStages; k++) begin
      if (!en[k]) v_d[k] = v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  cau_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .req_i  (in_req_i),
    .prod_o (prod)
  );

  cau_prep #(
    .FracBits (FracBits)
  ) u_prep (
    .clk_i  (clk_i),
    .en_i   (en[2:1]),
    .prod_i (prod),
    .side_o (side_s[0]),
    .iter_o (iter_s[0])
  );

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    cau_step u_step (
      .clk_i  (clk_i),
      .en_i   (en[k+3]),
      .side_i (side_s[k]),
      .iter_i (iter_s[k]),
      .side_o (side_s[k+1]),
      .iter_o (iter_s[k+1])
    );
  end

  cau_final u_final (
    .clk_i  (clk_i),
    .en_i   (en[NumStages-1]),
    .side_i (side_s[NumSteps]),
    .iter_i (iter_s[NumSteps]),
    .rsp_o  (out_rsp_o)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];

  // the input only stalls when every stage is full behind a held response
  `CAU_ASSERT_IMPL(a_stall_source, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output back-pressure")
  // a zero divisor always clears the result
  `CAU_ASSERT_IMPL(a_divzero_clear, out_valid_o && (out_rsp_o.status == StDivZero), (out_rsp_o.res_re == '0) && (out_rsp_o.res_im == '0), "zero divisor with nonzero result")
  // an accepted response with the pipe full frees the input in the same cycle
  `CAU_ASSERT_NEXT(a_full_drains, out_valid_o && out_ready_i && !in_ready_o, 1'b0, "input ready low while response taken")

endmodule

### design/cau_mult.sv
module cau_mult import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  req_t  req_i,
  output prod_t prod_o
);

  prod_t                       prod_d, prod_q;
  logic signed [DataWidth-1:0] sx, sy;

  always_comb begin
    // divide squares b, reciprocal and magnitude square a
    if (op_e'(req_i.op) == OpDiv) begin
      sx = req_i.b_re;
      sy = req_i.b_im;
    end else begin
      sx = req_i.a_re;
      sy = req_i.a_im;
    end
    prod_d.op   = req_i.op;
    prod_d.a_re = req_i.a_re;
    prod_d.a_im = req_i.a_im;
    prod_d.b_re = req_i.b_re;
    prod_d.b_im = req_i.b_im;
    prod_d.p_rr = $signed(req_i.a_re) * $signed(req_i.b_re);
    prod_d.p_ii = $signed(req_i.a_im) * $signed(req_i.b_im);
    prod_d.p_ir = $signed(req_i.a_im) * $signed(req_i.b_re);
    prod_d.p_ri = $signed(req_i.a_re) * $signed(req_i.b_im);
    prod_d.sq_x = ProdWidth'(sx * sx);
    prod_d.sq_y = ProdWidth'(sy * sy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

### design/cau_prep.sv
module cau_prep import cau_pkg::*; #(
  parameter int FracBits = 8
) (
  input  logic       clk_i,
  input  logic [1:0] en_i,
  input  prod_t      prod_i,
  output side_t      side_o,
  output iter_t      iter_o
);

  localparam int MagWidth = ProdWidth + 1;
  localparam int NumWidth = MagWidth + 2 * FracBits;

  logic signed [DataWidth-1:0] ar, ai, br, bi;
  logic signed [ProdWidth-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [DataWidth:0]   add_re, add_im, sub_re, sub_im, neg_ai;
  logic signed [ProdWidth:0]   mul_re, mul_im, div_re, div_im, ar_x, ai_x;
  logic [ProdWidth-1:0]        d;
  logic [DataWidth:0]          pk_re, pk_im;
  logic [MagWidth-1:0]         m_re, m_im;

  side_t                       side_a_d, side_a_q, side_b_d, side_b_q;
  logic [NumWidth-1:0]         n_re_d, n_im_d, n_re_q, n_im_q;
  logic [ProdWidth-1:0]        d_q;
  logic [NumWidth-1:0]         hi_re, hi_im;
  iter_t                       iter_d, iter_q;

  assign ar   = prod_i.a_re;
  assign ai   = prod_i.a_im;
  assign br   = prod_i.b_re;
  assign bi   = prod_i.b_im;
  assign p_rr = prod_i.p_rr;
  assign p_ii = prod_i.p_ii;
  assign p_ir = prod_i.p_ir;
  assign p_ri = prod_i.p_ri;

  assign add_re = ar + br;
  assign add_im = ai + bi;
  assign sub_re = ar - br;
  assign sub_im = ai - bi;
  assign neg_ai = -ai;
  assign mul_re = p_rr - p_ii;
  assign mul_im = p_ir + p_ri;
  assign div_re = p_rr + p_ii;
  assign div_im = p_ir - p_ri;
  assign ar_x   = ar;
  assign ai_x   = ai;
  assign d      = prod_i.sq_x + prod_i.sq_y;

  always_comb begin
    side_a_d    = '0;
    side_a_d.op = prod_i.op;
    n_re_d      = '0;
    n_im_d      = '0;
    pk_re       = '0;
    pk_im       = '0;
    m_re        = '0;
    m_im        = '0;
    case (op_e'(prod_i.op))
      OpAdd: begin
        pk_re = clamp_s(add_re);
        pk_im = clamp_s(add_im);
      end
      OpSub: begin
        pk_re = clamp_s(sub_re);
        pk_im = clamp_s(sub_im);
      end
      OpMul: begin
        // truncation toward zero: shift the magnitude
        m_re  = abs_s(mul_re) >> FracBits;
        m_im  = abs_s(mul_im) >> FracBits;
        pk_re = pack_mag(mul_re[ProdWidth], m_re);
        pk_im = pack_mag(mul_im[ProdWidth], m_im);
      end
      OpDiv: begin
        side_a_d.neg_re = div_re[ProdWidth];
        side_a_d.neg_im = div_im[ProdWidth];
        n_re_d = NumWidth'(abs_s(div_re)) << FracBits;
        n_im_d = NumWidth'(abs_s(div_im)) << FracBits;
      end
      OpRecip: begin
        // 1/a = conj(a) / |a|^2
        side_a_d.neg_re = ar[DataWidth-1];
        side_a_d.neg_im = !ai[DataWidth-1] && (ai != '0);
        n_re_d = NumWidth'(abs_s(ar_x)) << (2 * FracBits);
        n_im_d = NumWidth'(abs_s(ai_x)) << (2 * FracBits);
      end
      OpConj: begin
        pk_re = {1'b0, ar};
        pk_im = clamp_s(neg_ai);
      end
      default: begin
      end
    endcase
    side_a_d.res_re = pk_re[DataWidth-1:0];
    side_a_d.res_im = pk_im[DataWidth-1:0];
    side_a_d.sat    = pk_re[DataWidth] | pk_im[DataWidth];
    side_a_d.zero   = ((op_e'(prod_i.op) == OpDiv) || (op_e'(prod_i.op) == OpRecip))
                      && (d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_a_q <= side_a_d;
      n_re_q   <= n_re_d;
      n_im_q   <= n_im_d;
      d_q      <= d;
    end
  end

  // quotient fits the digit count only if n < d * 2^DataWidth
  always_comb begin
    hi_re           = n_re_q >> DataWidth;
    hi_im           = n_im_q >> DataWidth;
    side_b_d        = side_a_q;
    side_b_d.ovf_re = hi_re >= NumWidth'(d_q);
    side_b_d.ovf_im = hi_im >= NumWidth'(d_q);
    iter_d.d        = d_q;
    iter_d.rem_re   = hi_re[ProdWidth-1:0];
    iter_d.rem_im   = hi_im[ProdWidth-1:0];
    iter_d.lo_re    = n_re_q[DataWidth-1:0];
    iter_d.lo_im    = n_im_q[DataWidth-1:0];
    iter_d.q_re     = '0;
    iter_d.q_im     = '0;
    iter_d.sq_rem   = '0;
    iter_d.sq_root  = '0;
    iter_d.sq_v     = d_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      side_b_q <= side_b_d;
      iter_q   <= iter_d;
    end
  end

  assign side_o = side_b_q;
  assign iter_o = iter_q;

endmodule

### design/cau_step.sv
module cau_step import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  side_t side_i,
  input  iter_t iter_i,
  output side_t side_o,
  output iter_t iter_o
);

  logic [ProdWidth:0]   cand_re, cand_im, dx, diff_re, diff_im;
  logic                 ge_re, ge_im;
  logic [DataWidth+3:0] sq_cand, sq_trial, sq_diff;
  logic                 sq_ge;
  iter_t                iter_d, iter_q;
  side_t                side_q;

  always_comb begin
    // one restoring quotient digit for each part
    dx      = {1'b0, iter_i.d};
    cand_re = {iter_i.rem_re, iter_i.lo_re[DataWidth-1]};
    cand_im = {iter_i.rem_im, iter_i.lo_im[DataWidth-1]};
    diff_re = cand_re - dx;
    diff_im = cand_im - dx;
    ge_re   = cand_re >= dx;
    ge_im   = cand_im >= dx;

    // one root digit from the next two radicand bits
    sq_cand  = {iter_i.sq_rem, iter_i.sq_v[ProdWidth-1 -: 2]};
    sq_trial = (DataWidth+4)'({iter_i.sq_root, 2'b01});
    sq_diff  = sq_cand - sq_trial;
    sq_ge    = sq_cand >= sq_trial;

    iter_d.d       = iter_i.d;
    iter_d.rem_re  = ge_re ? diff_re[ProdWidth-1:0] : cand_re[ProdWidth-1:0];
    iter_d.rem_im  = ge_im ? diff_im[ProdWidth-1:0] : cand_im[ProdWidth-1:0];
    iter_d.lo_re   = {iter_i.lo_re[DataWidth-2:0], 1'b0};
    iter_d.lo_im   = {iter_i.lo_im[DataWidth-2:0], 1'b0};
    iter_d.q_re    = {iter_i.q_re[DataWidth-2:0], ge_re};
    iter_d.q_im    = {iter_i.q_im[DataWidth-2:0], ge_im};
    iter_d.sq_rem  = sq_ge ? sq_diff[DataWidth+1:0] : sq_cand[DataWidth+1:0];
    iter_d.sq_root = {iter_i.sq_root[DataWidth-2:0], sq_ge};
    iter_d.sq_v    = {iter_i.sq_v[ProdWidth-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      iter_q <= iter_d;
      side_q <= side_i;
    end
  end

  assign iter_o = iter_q;
  assign side_o = side_q;

endmodule

### design/cau_final.sv
module cau_final import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  side_t side_i,
  input  iter_t iter_i,
  output rsp_t  rsp_o
);

  logic [DataWidth:0] pk_re, pk_im, pk_rt;
  logic [ProdWidth:0] qm_re, qm_im;
  logic               sat;
  rsp_t               rsp_d, rsp_q;

  always_comb begin
    qm_re = side_i.ovf_re ? '1 : (ProdWidth+1)'(iter_i.q_re);
    qm_im = side_i.ovf_im ? '1 : (ProdWidth+1)'(iter_i.q_im);
    pk_re = pack_mag(side_i.neg_re, qm_re);
    pk_im = pack_mag(side_i.neg_im, qm_im);
    pk_rt = pack_mag(1'b0, (ProdWidth+1)'(iter_i.sq_root));

    rsp_d.res_re = side_i.res_re;
    rsp_d.res_im = side_i.res_im;
    sat          = side_i.sat;
    case (op_e'(side_i.op))
      OpDiv, OpRecip: begin
        if (side_i.zero) begin
          rsp_d.res_re = '0;
          rsp_d.res_im = '0;
          sat          = 1'b0;
        end else begin
          rsp_d.res_re = pk_re[DataWidth-1:0];
          rsp_d.res_im = pk_im[DataWidth-1:0];
          sat          = pk_re[DataWidth] | pk_im[DataWidth];
        end
      end
      OpMag: begin
        rsp_d.res_re = pk_rt[DataWidth-1:0];
        rsp_d.res_im = '0;
        sat          = pk_rt[DataWidth];
      end
      default: begin
      end
    endcase

    if (side_i.zero) rsp_d.status = StDivZero;
    else if (sat) rsp_d.status = StSat;
    else rsp_d.status = StOk;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

### dv/tb.sv
module tb;
  import cau_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  complex_arithmetic_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_rsp_o(out_rsp_o)
  );

  localparam int Frac = 8;
  localparam int Latency = DataWidth + 4;
  localparam int Watchdog = 20000;

  req_t pending_q[$];
  rsp_t expected_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_rx = 1'b0;   // long receiver hold-off request
  bit wait_drain = 1'b0;
  bit in_taken = 1'b0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int idle_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // saturate a sign/magnitude pair to the data range
  function automatic logic signed [15:0] sat_mag(input bit neg, input longint unsigned m,
                                                 inout bit sat);
    longint unsigned lim;
    lim = neg ? 64'd32768 : 64'd32767;
    if (m > lim) begin
      m = lim;
      sat = 1'b1;
    end
    return neg ? 16'(-longint'(m)) : 16'(m);
  endfunction

  function automatic logic signed [15:0] sat_val(input longint v, inout bit sat);
    return v < 0 ? sat_mag(1'b1, longint'(-v), sat) : sat_mag(1'b0, v, sat);
  endfunction

  // truncating (n << sh) / d, stopping once past the limit
  function automatic logic signed [15:0] quot(input bit neg, input longint unsigned n,
                                              input longint unsigned d, input int sh,
                                              inout bit sat);
    longint unsigned q, r, lim;
    lim = neg ? 64'd32768 : 64'd32767;
    q = n / d;
    r = n % d;
    for (int i = 0; i < sh && q <= lim; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        q++;
        r -= d;
      end
    end
    return sat_mag(neg, q, sat);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic rsp_t compute_result(input req_t r);
    rsp_t o;
    longint ar, ai, br, bi, s, d;
    bit sat, dz;
    ar = longint'(r.a_re);
    ai = longint'(r.a_im);
    br = longint'(r.b_re);
    bi = longint'(r.b_im);
    sat = 1'b0;
    dz = 1'b0;
    o = '0;
    case (op_e'(r.op))
      OpAdd: begin
        o.res_re = sat_val(ar + br, sat);
        o.res_im = sat_val(ai + bi, sat);
      end
      OpSub: begin
        o.res_re = sat_val(ar - br, sat);
        o.res_im = sat_val(ai - bi, sat);
      end
      OpMul: begin
        s = ar * br - ai * bi;
        o.res_re = sat_mag(s < 0, (s < 0 ? -s : s) >> Frac, sat);
        s = ai * br + ar * bi;
        o.res_im = sat_mag(s < 0, (s < 0 ? -s : s) >> Frac, sat);
      end
      OpDiv: begin
        d = br * br + bi * bi;
        if (d == 0) dz = 1'b1;
        else begin
          s = ar * br + ai * bi;
          o.res_re = quot(s < 0, s < 0 ? -s : s, d, Frac, sat);
          s = ai * br - ar * bi;
          o.res_im = quot(s < 0, s < 0 ? -s : s, d, Frac, sat);
        end
      end
      OpRecip: begin
        d = ar * ar + ai * ai;
        if (d == 0) dz = 1'b1;
        else begin
          o.res_re = quot(ar < 0, ar < 0 ? -ar : ar, d, 2 * Frac, sat);
          o.res_im = quot(ai > 0, ai < 0 ? -ai : ai, d, 2 * Frac, sat);
        end
      end
      OpMag: begin
        o.res_re = sat_mag(1'b0, floor_sqrt(ar * ar + ai * ai), sat);
      end
      OpConj: begin
        o.res_re = r.a_re;
        o.res_im = sat_val(-ai, sat);
      end
      default: ;
    endcase
    o.status = dz ? StDivZero : (sat ? StSat : StOk);
    return o;
  endfunction

  function automatic logic [15:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 8)) - 4);
      4, 5: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.op = 3'($urandom_range(0, 7));
    r.a_re = pick_val();
    r.a_im = pick_val();
    r.b_re = pick_val();
    r.b_im = pick_val();
    return r;
  endfunction

  task automatic add_req(input logic [2:0] op, input logic [15:0] ar, input logic [15:0] ai,
                         input logic [15:0] br, input logic [15:0] bi);
    req_t r;
    r.op = op;
    r.a_re = ar;
    r.a_im = ai;
    r.b_re = br;
    r.b_im = bi;
    pending_q.push_back(r);
  endtask

  task automatic wait_empty();
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    add_req(OpAdd, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    add_req(OpSub, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    add_req(OpMul, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    add_req(OpMul, 16'h0100, 16'h0200, 16'hff00, 16'h0080);
    add_req(OpDiv, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    add_req(OpDiv, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    add_req(OpDiv, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
    add_req(OpRecip, 16'h0000, 16'h0000, 16'h1234, 16'h5678);
    add_req(OpRecip, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    add_req(OpRecip, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    add_req(OpRecip, 16'hfe00, 16'h0300, 16'h0000, 16'h0000);
    add_req(OpMag, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
    add_req(OpMag, 16'h0300, 16'hfc00, 16'h0000, 16'h0000);
    add_req(OpConj, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    add_req(OpConj, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
    add_req(3'd7, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    wait_empty();
    // receiver stalls while the sender keeps pushing
    hold_rx = 1'b1;
    for (int i = 0; i < 60; i++) pending_q.push_back(rand_req());
    repeat (200) @(posedge clk_i);
    hold_rx = 1'b0;
    wait_empty();
    // sender pauses until everything has drained
    wait_drain = 1'b1;
    while (expected_q.size() != 0) @(posedge clk_i);
    wait_drain = 1'b0;
    for (int i = 0; i < 1300; i++) pending_q.push_back(rand_req());
    wait_empty();
    stim_done = 1'b1;
  end

  // request taken at the last rising edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
  end

  // driver
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
      // hold the request
    end else if (gap_cnt > 0) begin
      gap_cnt <= gap_cnt - 1;
      in_valid_i <= 1'b0;
    end else if (pending_q.size() != 0 && !wait_drain && rst_ni) begin
      in_req_i <= pending_q.pop_front();
      in_valid_i <= 1'b1;
      case ($urandom_range(0, 19))
        0: gap_cnt <= $urandom_range(10, 40);
        1, 2, 3: gap_cnt <= $urandom_range(1, 3);
        default: gap_cnt <= 0;
      endcase
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    if (hold_rx || !rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      case ($urandom_range(0, 19))
        0: stall_cnt <= $urandom_range(10, 40);
        1, 2, 3: stall_cnt <= $urandom_range(1, 3);
        default: stall_cnt <= 0;
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_q.push_back(compute_result(in_req_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected response %h", out_rsp_o);
          errors++;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_rsp_o.res_re !== exp_rsp.res_re) begin
            $error("res_re: expected %h, got %h", exp_rsp.res_re, out_rsp_o.res_re);
            errors++;
          end
          if (out_rsp_o.res_im !== exp_rsp.res_im) begin
            $error("res_im: expected %h, got %h", exp_rsp.res_im, out_rsp_o.res_im);
            errors++;
          end
          if (out_rsp_o.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp_o.status);
            errors++;
          end
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni ||
          hold_rx || (stim_done && expected_q.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= Watchdog) begin
        $display("[complex_arithmetic_unit] ERROR");
        $finish;
      end
      if (stim_done && expected_q.size() == 0) begin
        repeat (Latency + 10) @(posedge clk_i);
        if (errors == 0 && expected_q.size() == 0) begin
          $display("[complex_arithmetic_unit] OK");
        end else begin
          $display("[complex_arithmetic_unit] ERROR");
        end
        $finish;
      end
    end
  end
endmodule

### filelist.f
+incdir+design
design/cau_pkg.sv
design/cau_mult.sv
design/cau_prep.sv
design/cau_step.sv
design/cau_final.sv
design/complex_arithmetic_unit.sv
dv/tb.sv
